// ----- rtl/hsd_pkg.sv -----
// Shared constants for the Huffman stream decoder.
// No dependencies; used by huffman_stream_decoder_unit.
`timescale 1ns / 1ps

package hsd_pkg;

    // Default sizes of the node table and of the open-node stack
    localparam int MAX_NODES_DEFAULT   = 512;
    localparam int STACK_DEPTH_DEFAULT = 256;

    localparam int BYTE_W = 8;

    // Tree header markers
    localparam logic [BYTE_W-1:0] CHAR_INTERNAL = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CHAR_ESCAPE   = 8'h5C;  // backslash

    // Number of bits walked in a full data byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ----- rtl/hsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hsd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/huffman_stream_decoder_unit.sv -----
// Top level of the Huffman stream decoder: header parse, tree rebuild, bit-serial walk.
// Depends on hsd_pkg and hsd_ram.
`timescale 1ns / 1ps

// Channel  Handshake             Payload                 Direction
// -------  --------------------  ----------------------  ---------
// input    in_valid / in_stall   in_byte, is_last        into block
// output   out_valid / out_stall symbol, error, run_end  out of block
//
// Header and tree bytes are handled in ST_IDLE; a tree byte whose leaf closes
// an internal node also passes through ST_POP to reload the stack top from RAM
// unless the stack is then empty. A data byte is accepted, walked with one
// node-table read per walked bit (N = 1..8) through the registered read, and
// then flushed. Output stalls hold the walk when a second leaf is found while
// the previous result still waits.
// Reset clears all control state; node table and stack RAMs need no clearing.
// in_stall is high whenever the block is busy with the previous transaction.

module huffman_stream_decoder_unit #(
    parameter int MAX_NODES   = hsd_pkg::MAX_NODES_DEFAULT,
    parameter int STACK_DEPTH = hsd_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] symbol,
    output logic       error,
    output logic       run_end
);

    // Node index, node count, child payload, stack address and stack count widths
    localparam int NW  = $clog2(MAX_NODES);
    localparam int NUW = $clog2(MAX_NODES + 1);
    localparam int CW  = (NW > hsd_pkg::BYTE_W) ? NW : hsd_pkg::BYTE_W;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    // A child field holds a leaf flag and either the leaf symbol or the child index,
    // so one read per bit tells the walk both where to go and what to emit.
    typedef logic [CW:0] child_t;

    typedef struct packed {
        logic          left_done;
        logic [NW-1:0] idx;
    } stack_entry_t;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_TREE,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_WALK,
        ST_FLUSH,
        ST_ERR
    } state_t;

    // Registers
    state_t       state_reg,      state_next;
    phase_t       phase_reg,      phase_next;
    logic [2:0]   unused_reg,     unused_next;
    logic         esc_reg,        esc_next;
    logic         err_reg,        err_next;
    logic [NUW-1:0] nodes_reg,    nodes_next;
    logic [SCW-1:0] count_reg,    count_next;
    stack_entry_t top_reg,        top_next;
    logic [NW-1:0] walk_reg,      walk_next;
    logic         root_leaf_reg,  root_leaf_next;
    logic [7:0]   root_sym_reg,   root_sym_next;
    logic [7:0]   byte_reg,       byte_next;
    logic [3:0]   bits_reg,       bits_next;
    logic         pend_valid_reg, pend_valid_next;
    logic [7:0]   pend_sym_reg,   pend_sym_next;
    logic         out_valid_reg,  out_valid_next;
    logic [7:0]   symbol_reg,     symbol_next;
    logic         error_reg,      error_next;
    logic         run_end_reg,    run_end_next;

    // RAM ports
    logic          left_we;
    logic          right_we;
    logic [NW-1:0] node_wr_addr;
    child_t        node_wr_data;
    child_t        left_rd;
    child_t        right_rd;
    logic          stk_we;
    logic [SAW-1:0] stk_wr_addr;
    stack_entry_t  stk_wr_data;
    logic [SAW-1:0] stk_rd_addr;
    stack_entry_t  stk_rd;

    // Tree-building decode of the incoming byte
    logic           is_star;
    logic           is_bs;
    logic           add_node;
    logic           mk_leaf;
    logic [NW-1:0]  new_id;
    logic           node_full;
    logic           has_parent;
    logic           popped;
    logic [SCW-1:0] cnt_after;
    logic [SCW-1:0] cnt_m1;
    logic [SCW-1:0] cnt_m2;
    logic           stk_full;
    child_t         new_field;

    // Walk step
    child_t         child;
    logic           step_leaf;
    logic [7:0]     step_sym;
    logic [NW-1:0]  step_node;
    logic           out_free;

    hsd_ram #(
        .WIDTH (CW + 1),
        .DEPTH (MAX_NODES)
    ) u_left_ram (
        .clk     (clk),
        .wr_en   (left_we),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data),
        .rd_addr (walk_next),
        .rd_data (left_rd)
    );

    hsd_ram #(
        .WIDTH (CW + 1),
        .DEPTH (MAX_NODES)
    ) u_right_ram (
        .clk     (clk),
        .wr_en   (right_we),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data),
        .rd_addr (walk_next),
        .rd_data (right_rd)
    );

    hsd_ram #(
        .WIDTH (NW + 1),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd)
    );

    // Classify the tree byte and work out where the new node attaches
    always_comb
    begin
        is_star    = !esc_reg && (in_byte == hsd_pkg::CHAR_INTERNAL);
        is_bs      = !esc_reg && (in_byte == hsd_pkg::CHAR_ESCAPE);
        add_node   = !is_bs;
        mk_leaf    = !is_star;
        new_id     = nodes_reg[NW-1:0];
        node_full  = nodes_reg >= NUW'(MAX_NODES);
        has_parent = count_reg != '0;
        popped     = has_parent && top_reg.left_done;
        cnt_after  = count_reg - SCW'(popped);
        cnt_m1     = count_reg - SCW'(1);
        cnt_m2     = count_reg - SCW'(2);
        stk_full   = !mk_leaf && (cnt_after >= SCW'(STACK_DEPTH));
        new_field  = {mk_leaf, mk_leaf ? CW'(in_byte) : CW'(new_id)};
    end

    // One walk step: follow the current bit from the node read last cycle
    always_comb
    begin
        child = byte_reg[7] ? right_rd : left_rd;
        if (root_leaf_reg)
        begin
            step_leaf = 1'b1;
            step_sym  = root_sym_reg;
            step_node = '0;
        end
        else
        begin
            step_leaf = child[CW];
            step_sym  = child[7:0];
            step_node = child[CW] ? '0 : child[NW-1:0];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        unused_next     = unused_reg;
        esc_next        = esc_reg;
        err_next        = err_reg;
        nodes_next      = nodes_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        walk_next       = walk_reg;
        root_leaf_next  = root_leaf_reg;
        root_sym_next   = root_sym_reg;
        byte_next       = byte_reg;
        bits_next       = bits_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        out_valid_next  = out_valid_reg && out_stall;
        symbol_next     = symbol_reg;
        error_next      = error_reg;
        run_end_next    = run_end_reg;

        left_we      = 1'b0;
        right_we     = 1'b0;
        node_wr_addr = top_reg.idx;
        node_wr_data = new_field;
        stk_we       = 1'b0;
        stk_wr_addr  = cnt_m1[SAW-1:0];
        stk_wr_data  = '{left_done: 1'b1, idx: top_reg.idx};
        stk_rd_addr  = cnt_m2[SAW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (err_reg)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_HDR0:
                            begin
                                unused_next = in_byte[7:5];
                                esc_next    = 1'b0;
                                count_next  = '0;
                                nodes_next  = '0;
                                walk_next   = '0;
                                phase_next  = is_last ? PH_HDR0 : PH_HDR1;
                            end
                            PH_HDR1:
                            begin
                                phase_next = is_last ? PH_HDR0 : PH_TREE;
                            end
                            PH_TREE:
                            begin
                                if (add_node && (node_full || stk_full))
                                begin
                                    // overflow: go sticky and report
                                    err_next   = 1'b1;
                                    state_next = ST_ERR;
                                end
                                else
                                begin
                                    if (add_node)
                                    begin
                                        nodes_next = nodes_reg + NUW'(1);
                                        esc_next   = 1'b0;
                                        if (nodes_reg == '0)
                                        begin
                                            root_leaf_next = mk_leaf;
                                            root_sym_next  = in_byte;
                                        end
                                        if (has_parent)
                                        begin
                                            if (!popped)
                                            begin
                                                left_we            = 1'b1;
                                                top_next.left_done = 1'b1;
                                            end
                                            else
                                            begin
                                                right_we = 1'b1;
                                            end
                                        end
                                        if (!mk_leaf)
                                        begin
                                            // push: spill the old top unless it was just closed
                                            top_next = '{left_done: 1'b0, idx: new_id};
                                            if (!popped)
                                            begin
                                                stk_we     = has_parent;
                                                count_next = count_reg + SCW'(1);
                                            end
                                        end
                                        else if (popped)
                                        begin
                                            count_next = cnt_after;
                                            if (cnt_after != '0)
                                            begin
                                                state_next = ST_POP;
                                            end
                                        end
                                        if (mk_leaf && (cnt_after == '0))
                                        begin
                                            phase_next = PH_DATA;
                                            walk_next  = '0;
                                        end
                                    end
                                    else
                                    begin
                                        esc_next = 1'b1;
                                    end
                                    if (is_last)
                                    begin
                                        esc_next   = 1'b0;
                                        phase_next = PH_HDR0;
                                    end
                                end
                            end
                            PH_DATA:
                            begin
                                byte_next  = in_byte;
                                bits_next  = is_last
                                           ? hsd_pkg::BITS_PER_BYTE - {1'b0, unused_reg}
                                           : hsd_pkg::BITS_PER_BYTE;
                                phase_next = is_last ? PH_HDR0 : PH_DATA;
                                state_next = ST_WALK;
                            end
                            default:
                            begin
                                phase_next = PH_HDR0;
                            end
                        endcase
                    end
                end
            end

            ST_POP:
            begin
                top_next   = stk_rd;
                state_next = ST_IDLE;
            end

            ST_WALK:
            begin
                // hold when a second leaf shows up and the output is still full
                if (!(step_leaf && pend_valid_reg && !out_free))
                begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    bits_next = bits_reg - 4'd1;
                    walk_next = step_node;
                    if (step_leaf)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            symbol_next    = pend_sym_reg;
                            error_next     = 1'b0;
                            run_end_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = step_sym;
                    end
                    if (bits_reg == 4'd1)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    symbol_next     = pend_sym_reg;
                    error_next      = 1'b0;
                    run_end_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = '0;
                    error_next     = 1'b1;
                    run_end_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_HDR0;
            unused_reg     <= '0;
            esc_reg        <= 1'b0;
            err_reg        <= 1'b0;
            nodes_reg      <= '0;
            count_reg      <= '0;
            top_reg        <= '0;
            walk_reg       <= '0;
            root_leaf_reg  <= 1'b0;
            root_sym_reg   <= '0;
            byte_reg       <= '0;
            bits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_sym_reg   <= '0;
            out_valid_reg  <= 1'b0;
            symbol_reg     <= '0;
            error_reg      <= 1'b0;
            run_end_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            unused_reg     <= unused_next;
            esc_reg        <= esc_next;
            err_reg        <= err_next;
            nodes_reg      <= nodes_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            walk_reg       <= walk_next;
            root_leaf_reg  <= root_leaf_next;
            root_sym_reg   <= root_sym_next;
            byte_reg       <= byte_next;
            bits_reg       <= bits_next;
            pend_valid_reg <= pend_valid_next;
            pend_sym_reg   <= pend_sym_next;
            out_valid_reg  <= out_valid_next;
            symbol_reg     <= symbol_next;
            error_reg      <= error_next;
            run_end_reg    <= run_end_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign error     = error_reg;
    assign run_end   = run_end_reg;

endmodule
